// ===== rtl/hc2_pkg.sv =====
// ----------------------------------------------------------------------------
// hc2_pkg: shared types and constants for the 2x2 Hill cipher
// Item layouts for both channels, the pair handed from front to back,
// the key register group and the register map of the configuration port.
// ----------------------------------------------------------------------------
package hc2_pkg;

  localparam int unsigned LETTER_W            = 5;
  localparam int unsigned MODULUS_DEFAULT     = 26;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam int unsigned APB_AW    = 5;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned REG_IDX_W = 3;

  // register map, word index into the configuration space
  localparam logic [REG_IDX_W-1:0] REG_KEY_A = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_B = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_C = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_D = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MODE  = 3'd4;

  typedef logic [LETTER_W-1:0] letter_t;

  typedef struct packed {
    letter_t letter_in;
    logic    end_of_message;
  } in_item_t;

  typedef struct packed {
    letter_t out_first;
    letter_t out_second;
    logic    second_valid;
    logic    final_pair;
  } out_item_t;

  // one digraph ready for the arithmetic
  typedef struct packed {
    letter_t p0;
    letter_t p1;
    logic    second_valid;
    logic    final_pair;
  } pair_t;

  typedef struct packed {
    letter_t key_a;
    letter_t key_b;
    letter_t key_c;
    letter_t key_d;
    logic    mode;
  } key_cfg_t;

endpackage

// ===== rtl/hc2_front.sv =====
// ----------------------------------------------------------------------------
// hc2_front: letter pairing
// Holds the first letter of a digraph, pushes complete pairs into the queue,
// pads an odd encrypt tail and drops an odd decrypt tail.
// ----------------------------------------------------------------------------
module hc2_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hc2_pkg::in_item_t in_item_i,
  input  logic             mode_i,
  input  logic             full_i,
  output logic             push_o,
  output hc2_pkg::pair_t   push_item_o
);
  import hc2_pkg::*;

  letter_t held_letter_q, held_letter_d;
  logic    have_held_q, have_held_d;
  logic    acc;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && !full_i;

  always_comb begin
    held_letter_d            = held_letter_q;
    have_held_d              = have_held_q;
    push_o                   = 1'b0;
    push_item_o.p0           = held_letter_q;
    push_item_o.p1           = in_item_i.letter_in;
    push_item_o.second_valid = 1'b1;
    push_item_o.final_pair   = in_item_i.end_of_message;
    if (acc) begin
      if (have_held_q) begin
        push_o        = 1'b1;
        have_held_d   = 1'b0;
        held_letter_d = '0;
      end else if (!in_item_i.end_of_message) begin
        held_letter_d = in_item_i.letter_in;
        have_held_d   = 1'b1;
      end else if (!mode_i) begin
        // lone last letter: pad with zero, flag the pad
        push_o                   = 1'b1;
        push_item_o.p0           = in_item_i.letter_in;
        push_item_o.p1           = '0;
        push_item_o.second_valid = 1'b0;
        push_item_o.final_pair   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_letter_q <= '0;
      have_held_q   <= 1'b0;
    end else begin
      held_letter_q <= held_letter_d;
      have_held_q   <= have_held_d;
    end
  end

  a_pair_clears_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && have_held_q) |=> !have_held_q)
    else $error("held letter survived the completion of its pair");

endmodule

// ===== rtl/hc2_queue.sv =====
// ----------------------------------------------------------------------------
// hc2_queue: pair queue
// Short first-in first-out buffer that decouples pairing from arithmetic.
// ----------------------------------------------------------------------------
module hc2_queue #(
  parameter int unsigned DEPTH = hc2_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hc2_pkg::pair_t push_item_i,
  output logic           full_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output hc2_pkg::pair_t pop_item_o
);
  import hc2_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pair_t           mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            pop;

  assign full_o      = (count_q == CW'(DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("pair pushed into a full queue");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill count lost a pushed item");

endmodule

// ===== rtl/hc2_back.sv =====
// ----------------------------------------------------------------------------
// hc2_back: modular matrix pipeline
// Nine registered stages: reduce operands, determinant, inverse table,
// inverse key matrix, matrix times pair, final reduction into the output.
// ----------------------------------------------------------------------------
module hc2_back #(
  parameter int unsigned MODULUS = hc2_pkg::MODULUS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hc2_pkg::key_cfg_t  cfg_i,
  input  logic               pair_valid_i,
  output logic               pair_ready_o,
  input  hc2_pkg::pair_t     pair_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hc2_pkg::out_item_t out_item_o
);
  import hc2_pkg::*;

  localparam int unsigned RW     = $clog2(MODULUS);
  localparam int unsigned PW     = 2 * RW;
  localparam int unsigned XW     = 2 * RW + 1;
  localparam int unsigned SW     = LETTER_W + RW;
  localparam int unsigned NSTAGE = 9;
  localparam int unsigned LAST   = NSTAGE - 1;

  typedef logic [RW-1:0] res_t;
  typedef logic [PW-1:0] prod_t;
  typedef res_t inv_tbl_t [MODULUS];

  typedef struct packed {
    logic  mode;
    logic  sv;
    logic  fp;
    res_t  p0, p1;
    res_t  ka, kb, kc, kd;
    res_t  mad, mbc, det, inv;
    res_t  m00, m01, m10, m11;
    res_t  r0, r1;
    prod_t t0, t1, t2, t3;
  } pipe_t;

  function automatic inv_tbl_t build_inv();
    inv_tbl_t    tbl;
    int unsigned acc;
    for (int unsigned j = 0; j < MODULUS; j++) begin
      tbl[j] = '0;
      acc    = 0;
      for (int unsigned i = 1; i < MODULUS; i++) begin
        acc = acc + j;
        if (acc >= MODULUS) acc = acc - MODULUS;
        if (acc == 1 && tbl[j] == '0) tbl[j] = res_t'(i);
      end
    end
    return tbl;
  endfunction

  localparam inv_tbl_t INV_TBL = build_inv();

  // reduce a raw 5-bit code by shifted compare and subtract
  function automatic res_t mod_letter(input letter_t x);
    logic [SW-1:0] v;
    logic [SW-1:0] m;
    v = SW'(x);
    m = SW'(MODULUS);
    for (int i = LETTER_W - 1; i >= 0; i--) begin
      if (v >= (m << i)) v = v - (m << i);
    end
    return v[RW-1:0];
  endfunction

  // reduce a product or a sum of two products of residues
  function automatic res_t mod_wide(input logic [XW-1:0] x);
    logic [XW-1:0] v;
    logic [XW-1:0] m;
    v = x;
    m = XW'(MODULUS);
    for (int i = RW; i >= 0; i--) begin
      if (v >= (m << i)) v = v - (m << i);
    end
    return v[RW-1:0];
  endfunction

  function automatic res_t neg_mod(input res_t x);
    return (x == '0) ? '0 : res_t'(MODULUS - 32'(x));
  endfunction

  function automatic prod_t mul(input res_t a, input res_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  pipe_t               s_q [NSTAGE];
  pipe_t               s_d [NSTAGE];
  logic [NSTAGE-1:0]   vld_q, vld_d;
  logic                stall, en;

  assign stall        = vld_q[LAST] && !out_ready_i;
  assign en           = !stall;
  assign pair_ready_o = en;
  assign vld_d        = {vld_q[NSTAGE-2:0], pair_valid_i};

  always_comb begin
    // stage 0: reduce letters and keys
    s_d[0]      = '0;
    s_d[0].mode = cfg_i.mode;
    s_d[0].sv   = pair_i.second_valid;
    s_d[0].fp   = pair_i.final_pair;
    s_d[0].p0   = mod_letter(pair_i.p0);
    s_d[0].p1   = mod_letter(pair_i.p1);
    s_d[0].ka   = mod_letter(cfg_i.key_a);
    s_d[0].kb   = mod_letter(cfg_i.key_b);
    s_d[0].kc   = mod_letter(cfg_i.key_c);
    s_d[0].kd   = mod_letter(cfg_i.key_d);

    // stage 1: determinant products
    s_d[1]    = s_q[0];
    s_d[1].t0 = mul(s_q[0].ka, s_q[0].kd);
    s_d[1].t1 = mul(s_q[0].kb, s_q[0].kc);

    // stage 2: reduce them
    s_d[2]     = s_q[1];
    s_d[2].mad = mod_wide(XW'(s_q[1].t0));
    s_d[2].mbc = mod_wide(XW'(s_q[1].t1));

    // stage 3: determinant, kept in range
    s_d[3] = s_q[2];
    if (s_q[2].mad >= s_q[2].mbc) begin
      s_d[3].det = s_q[2].mad - s_q[2].mbc;
    end else begin
      s_d[3].det = res_t'(MODULUS - 32'(s_q[2].mbc) + 32'(s_q[2].mad));
    end

    // stage 4: inverse of the determinant, zero when singular
    s_d[4]     = s_q[3];
    s_d[4].inv = INV_TBL[s_q[3].det];

    // stage 5: adjugate times inverse
    s_d[5]    = s_q[4];
    s_d[5].t0 = mul(s_q[4].kd, s_q[4].inv);
    s_d[5].t1 = mul(s_q[4].kb, s_q[4].inv);
    s_d[5].t2 = mul(s_q[4].kc, s_q[4].inv);
    s_d[5].t3 = mul(s_q[4].ka, s_q[4].inv);

    // stage 6: pick key or inverse key
    s_d[6] = s_q[5];
    if (s_q[5].mode) begin
      s_d[6].m00 = mod_wide(XW'(s_q[5].t0));
      s_d[6].m01 = neg_mod(mod_wide(XW'(s_q[5].t1)));
      s_d[6].m10 = neg_mod(mod_wide(XW'(s_q[5].t2)));
      s_d[6].m11 = mod_wide(XW'(s_q[5].t3));
    end else begin
      s_d[6].m00 = s_q[5].ka;
      s_d[6].m01 = s_q[5].kb;
      s_d[6].m10 = s_q[5].kc;
      s_d[6].m11 = s_q[5].kd;
    end

    // stage 7: matrix times pair
    s_d[7]    = s_q[6];
    s_d[7].t0 = mul(s_q[6].m00, s_q[6].p0);
    s_d[7].t1 = mul(s_q[6].m01, s_q[6].p1);
    s_d[7].t2 = mul(s_q[6].m10, s_q[6].p0);
    s_d[7].t3 = mul(s_q[6].m11, s_q[6].p1);

    // stage 8: sum and reduce into the output register
    s_d[8]    = s_q[7];
    s_d[8].r0 = mod_wide(XW'(s_q[7].t0) + XW'(s_q[7].t1));
    s_d[8].r1 = mod_wide(XW'(s_q[7].t2) + XW'(s_q[7].t3));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q <= s_d;
    end
  end

  assign out_valid_o             = vld_q[LAST];
  assign out_item_o.out_first    = letter_t'(s_q[LAST].r0);
  assign out_item_o.out_second   = letter_t'(s_q[LAST].r1);
  assign out_item_o.second_valid = s_q[LAST].sv;
  assign out_item_o.final_pair   = s_q[LAST].fp;

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(vld_q))
    else $error("pipeline advanced while the output item was stalled");

  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LAST] |-> (32'(s_q[LAST].r0) < MODULUS && 32'(s_q[LAST].r1) < MODULUS))
    else $error("result letter not reduced below the modulus");

endmodule

// ===== rtl/hill_cipher_2x2_mod26.sv =====
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod26: streaming 2x2 Hill cipher
// Pairs letters into digraphs and multiplies each pair by the key matrix,
// or by its modular inverse, with registers on an APB-style port.
// ----------------------------------------------------------------------------
// The block takes one letter (0..25) per cycle while the pair queue is not
// full and returns one item per digraph. Every other letter completes a pair;
// that pair passes through the pair queue and the arithmetic pipeline before
// it leaves the output register, and pairs follow back to back, so the
// sustained rate is one letter per cycle when the output does not stall. The
// arithmetic pipeline has a stage each for operand reduction, determinant,
// inverse table, inverse key matrix, matrix product and final reduction. In
// encrypt mode (mode 0) a lone last letter is padded with 0 and its item has
// second_valid low; in decrypt mode it is dropped. A key whose determinant has
// no inverse decrypts every letter to 0. Keys and mode live at byte addresses
// 0x00, 0x04, 0x08, 0x0C and 0x10 and may be written only while no pair is in
// flight; a letter waiting for its partner takes the mode in force when its
// pair enters the arithmetic pipeline.
module hill_cipher_2x2_mod26 #(
  parameter int unsigned MODULUS     = hc2_pkg::MODULUS_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = hc2_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  hc2_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output hc2_pkg::out_item_t           out_item_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hc2_pkg::APB_AW-1:0]   paddr,
  input  logic [hc2_pkg::APB_DW-1:0]   pwdata,
  output logic [hc2_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import hc2_pkg::*;

  key_cfg_t            cfg_q;
  logic                cfg_we;
  logic [REG_IDX_W-1:0] reg_idx;

  logic  push, full;
  pair_t push_item, pop_item;
  logic  pop_valid, pop_ready;

  // Register port: no wait states, write on the access phase.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_a <= LETTER_W'(9);
      cfg_q.key_b <= LETTER_W'(4);
      cfg_q.key_c <= LETTER_W'(5);
      cfg_q.key_d <= LETTER_W'(7);
      cfg_q.mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_KEY_A: cfg_q.key_a <= pwdata[LETTER_W-1:0];
        REG_KEY_B: cfg_q.key_b <= pwdata[LETTER_W-1:0];
        REG_KEY_C: cfg_q.key_c <= pwdata[LETTER_W-1:0];
        REG_KEY_D: cfg_q.key_d <= pwdata[LETTER_W-1:0];
        REG_MODE:  cfg_q.mode  <= pwdata[0];
        default: ;  // drop writes outside the map
      endcase
    end
  end

  // Read back the addressed register; unmapped words read as zero.
  always_comb begin
    unique case (reg_idx)
      REG_KEY_A: prdata = APB_DW'(cfg_q.key_a);
      REG_KEY_B: prdata = APB_DW'(cfg_q.key_b);
      REG_KEY_C: prdata = APB_DW'(cfg_q.key_c);
      REG_KEY_D: prdata = APB_DW'(cfg_q.key_d);
      REG_MODE:  prdata = APB_DW'(cfg_q.mode);
      default:   prdata = '0;
    endcase
  end

  // Front end: pair letters, pad or drop the odd tail.
  hc2_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .mode_i      (cfg_q.mode),
    .full_i      (full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // Queue: lets the front keep taking letters while the back end stalls.
  hc2_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  // Back end: modular matrix arithmetic, output register at its tail.
  hc2_back #(
    .MODULUS (MODULUS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pair_valid_i (pop_valid),
    .pair_ready_o (pop_ready),
    .pair_i       (pop_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule
